>>> hdl/lrupr_pkg.sv
package lrupr_pkg;

  localparam int NFRAMES_DEF   = 8;
  localparam int PAGE_BITS_DEF = 20;
  localparam int CFG_W         = 4;
  localparam int SLOT_W        = 3;
  localparam int TOTAL_W       = 32;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

  // status of one finished reference, engine to output stage
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              ev_valid;
  } lrupr_res_t;

endpackage

>>> hdl/lru_page_replacement.sv
// lru page replacement unit
//
// input channel (in_valid / in_ready / page): one page reference per
// transaction. output channel (out_valid / out_ready): one result per
// reference, giving hit, the frame slot now holding the page, the evicted
// page on a replacement, and saturating fault and hit totals.
// configuration channel (cfg_valid / cfg_ready / frames_in_use): sets how many
// frames may be used; always ready, write it only while the block is idle.
//
// frame pages and recency ranks live in one synchronous ram; each reference
// makes a scan pass (one frame read per cycle), a decision cycle and a
// read-modify-write pass over the frames, each pass reading the frames in
// turn through the single read port of the frame ram; references are
// handled one at a time, and the next one is accepted only after the last
// one has finished.
//
// reset clears all frame valid bits, both totals and sets frames_in_use to 8.
// the next reference is accepted while a result still waits in the output
// register; when the receiver stalls, the following result is held inside
// until the output register frees up.
module lru_page_replacement import lrupr_pkg::*; #(
  parameter int NFRAMES   = NFRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     frames_in_use,
  // page reference in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] page,
  // result out
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [SLOT_W-1:0]    slot,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [TOTAL_W-1:0]   fault_count,
  output logic [TOTAL_W-1:0]   hit_count
);

  logic [CFG_W-1:0]     frames_reg;
  logic                 out_free;
  logic                 done;
  lrupr_res_t           res;
  logic [PAGE_BITS-1:0] ev_page;

  assign cfg_ready = 1'b1;
  // output register can take a new result when empty or being drained
  assign out_free  = !out_valid || out_ready;

  lrupr_engine #(
    .NFRAMES   (NFRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .frames_in_use (frames_reg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page          (page),
    .out_free      (out_free),
    .done          (done),
    .res           (res),
    .ev_page       (ev_page)
  );

  // configuration register, output valid and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_reg  <= FRAMES_RESET;
      out_valid   <= 1'b0;
      fault_count <= '0;
      hit_count   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frames_reg <= frames_in_use;
      end
      if (done) begin
        out_valid <= 1'b1;
        // totals move only with a new result, so they hold while stalled
        if (res.hit) begin
          if (hit_count != TOTAL_MAX) begin
            hit_count <= hit_count + TOTAL_W'(1);
          end
        end else if (fault_count != TOTAL_MAX) begin
          fault_count <= fault_count + TOTAL_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (done) begin
      hit           <= res.hit;
      slot          <= res.slot;
      evicted_valid <= res.ev_valid;
      evicted_page  <= ev_page;
    end
  end

endmodule

>>> hdl/lrupr_mem.sv
module lrupr_mem import lrupr_pkg::*; #(
  parameter int DEPTH = NFRAMES_DEF,
  parameter int AW    = 3,
  parameter int DW    = PAGE_BITS_DEF + 3
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= ram[rd_addr];
    end
  end

endmodule

>>> hdl/lrupr_engine.sv
module lrupr_engine import lrupr_pkg::*; #(
  parameter int NFRAMES   = NFRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CFG_W-1:0]     frames_in_use,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 out_free,
  output logic                 done,
  output lrupr_res_t           res,
  output logic [PAGE_BITS-1:0] ev_page
);

  localparam int IW = (NFRAMES > 1) ? $clog2(NFRAMES) : 1;
  localparam int RW = IW;
  localparam int CW = $clog2(NFRAMES + 1);
  localparam int DW = PAGE_BITS + RW;
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [CW-1:0] N_C = CW'(NFRAMES);
  localparam logic [LW-1:0] N_L = LW'(NFRAMES);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]        cnt;
  logic                 rd_vld;
  logic [IW-1:0]        rd_q;
  logic [NFRAMES-1:0]   vbits;

  logic [PAGE_BITS-1:0] pg;
  logic                 found;
  logic [IW-1:0]        hit_slot;
  logic [RW-1:0]        hit_rank;
  logic [CW-1:0]        count;
  logic                 free_any;
  logic [IW-1:0]        free_slot;
  logic                 vic_any;
  logic [IW-1:0]        vic_slot;
  logic [RW-1:0]        worst;
  logic [PAGE_BITS-1:0] vic_page;
  logic [IW-1:0]        tgt;
  logic [RW-1:0]        old_rank;
  logic                 all_older;

  // memory port signals
  logic                 mem_rd_en;
  logic [DW-1:0]        mem_rd_data;
  logic                 mem_wr_en;
  logic [DW-1:0]        mem_wr_data;
  logic [PAGE_BITS-1:0] rd_page;
  logic [RW-1:0]        rd_rank;

  // decision logic
  logic [LW-1:0]        lim;
  logic                 is_fill;
  logic [IW-1:0]        tgt_next;
  logic [IW+SLOT_W-1:0] tgt_ext;

  lrupr_mem #(
    .DEPTH (NFRAMES),
    .AW    (IW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (cnt[IW-1:0]),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (rd_q),
    .wr_data (mem_wr_data)
  );

  assign rd_page = mem_rd_data[DW-1:RW];
  assign rd_rank = mem_rd_data[RW-1:0];

  assign in_ready  = (state == ST_IDLE);
  assign mem_rd_en = ((state == ST_SCAN) || (state == ST_UPDATE)) && (cnt < N_C);
  assign done      = (state == ST_FINISH) && out_free;

  // rank update pass: target goes to rank 0, younger valid frames (all valid frames on a fill) age by one
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_data = {rd_page, rd_rank + RW'(1)};
    if ((state == ST_UPDATE) && rd_vld) begin
      if (rd_q == tgt) begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {pg, {RW{1'b0}}};
      end else if (vbits[rd_q] && (all_older || (rd_rank < old_rank))) begin
        mem_wr_en = 1'b1;
      end
    end
  end

  always_comb begin
    lim = (frames_in_use == '0) ? LW'(1) : LW'(frames_in_use);
    if (lim > N_L) begin
      lim = N_L;
    end
    is_fill = !found && (LW'(count) < lim);
    if (found) begin
      tgt_next = hit_slot;
    end else if (is_fill) begin
      tgt_next = free_slot;
    end else begin
      tgt_next = vic_slot;
    end
    tgt_ext = {{SLOT_W{1'b0}}, tgt_next};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (cnt == N_C) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_UPDATE;
      ST_UPDATE: if (cnt == N_C) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_vld <= 1'b0;
      vbits  <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= mem_rd_en;
      if ((state == ST_DECIDE) && is_fill) begin
        vbits[tgt_next] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_q <= cnt[IW-1:0];
    if (mem_rd_en) begin
      cnt <= cnt + CW'(1);
    end
    unique case (state)
      ST_IDLE: begin
        cnt      <= '0;
        pg       <= page;
        found    <= 1'b0;
        count    <= '0;
        free_any <= 1'b0;
        vic_any  <= 1'b0;
      end
      ST_SCAN: begin
        if (rd_vld) begin
          if (vbits[rd_q]) begin
            count <= count + CW'(1);
            if (!found && (rd_page == pg)) begin
              found    <= 1'b1;
              hit_slot <= rd_q;
              hit_rank <= rd_rank;
            end
            if (!vic_any || (rd_rank > worst)) begin
              vic_any  <= 1'b1;
              vic_slot <= rd_q;
              worst    <= rd_rank;
              vic_page <= rd_page;
            end
          end else if (!free_any) begin
            free_any  <= 1'b1;
            free_slot <= rd_q;
          end
        end
      end
      ST_DECIDE: begin
        cnt          <= '0;
        tgt          <= tgt_next;
        old_rank     <= found ? hit_rank : worst;
        all_older    <= is_fill;
        res.hit      <= found;
        res.slot     <= tgt_ext[SLOT_W-1:0];
        res.ev_valid <= !found && !is_fill;
        ev_page      <= (!found && !is_fill) ? vic_page : '0;
      end
      ST_UPDATE: begin
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

endmodule
